// ----- design/polygon_area_convexity_bbox_core_defines.svh -----
// Assertion macros shared by the polygon area, convexity and box core.
`ifndef POLYGON_AREA_CONVEXITY_BBOX_CORE_DEFINES_SVH
`define POLYGON_AREA_CONVEXITY_BBOX_CORE_DEFINES_SVH

// The enclosing module must have clk and arst_n in scope.
// The consequent must hold in the same cycle as the antecedent.
`define PACB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PACB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The condition must never hold.
`define PACB_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ----- design/pacb_pkg.sv -----
// Shared widths, item types and arithmetic helpers for the polygon core.
`default_nettype none

package pacb_pkg;

	// coordinate and arithmetic widths
	localparam int COORD_W = 24;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int AREA_W = 58;
	localparam int EPS_W = 20;

	// vertex count
	localparam int MAX_VERTICES = 64;
	localparam int COUNT_W = $clog2(MAX_VERTICES + 1);

	// queue sizes (powers of two)
	localparam int JQ_DEPTH = 4;
	localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
	localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);
	localparam int RB_DEPTH = 2;
	localparam int RB_PTR_W = $clog2(RB_DEPTH);
	localparam int RB_CNT_W = $clog2(RB_DEPTH + 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;
	typedef logic signed [AREA_W-1:0]  area_t;
	typedef logic [COUNT_W-1:0]        count_t;

	// running turn extremes start at the widest values
	localparam cross_t TURN_HI = {1'b0, {(CROSS_W-1){1'b1}}};
	localparam cross_t TURN_LO = {1'b1, {(CROSS_W-1){1'b0}}};

	// operands of one cross product a x b
	typedef struct packed {
		diff_t ax;
		diff_t ay;
		diff_t bx;
		diff_t by;
	} xpair_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t max_x;
		coord_t max_y;
	} box_t;

	// classified vertex, front to back
	typedef struct packed {
		xpair_t area;
		xpair_t turn_mid;
		xpair_t turn_last;
		xpair_t turn_first;
		logic   turn_mid_v;
		logic   turn_end_v;
		logic   enough;
		logic   final_v;
		box_t   box;
		count_t count;
		logic   ovf;
	} job_t;

	typedef struct packed {
		prod_t ab;
		prod_t ba;
	} pprod_t;

	// registered products of one vertex
	typedef struct packed {
		pprod_t area;
		pprod_t turn_mid;
		pprod_t turn_last;
		pprod_t turn_first;
		logic   turn_mid_v;
		logic   turn_end_v;
		logic   enough;
		logic   final_v;
		box_t   box;
		count_t count;
		logic   ovf;
	} prods_t;

	// closing totals of one polygon
	typedef struct packed {
		area_t  area;
		cross_t tmin;
		cross_t tmax;
		logic   enough;
		box_t   box;
		count_t count;
		logic   ovf;
	} totals_t;

	typedef struct packed {
		logic [AREA_W-1:0] twice_area;
		logic   was_clockwise;
		logic   convex;
		box_t   box;
		count_t count;
		logic   ovf;
	} result_t;

	function automatic diff_t diff(input coord_t a, input coord_t b);
		diff = DIFF_W'(a) - DIFF_W'(b);
	endfunction

	function automatic prod_t mul(input diff_t a, input diff_t b);
		mul = a * b;
	endfunction

	function automatic cross_t cross_of(input pprod_t p);
		cross_of = CROSS_W'(p.ab) - CROSS_W'(p.ba);
	endfunction

endpackage

`default_nettype wire

// ----- design/pacb_job_q.sv -----
// Short queue of classified vertices between the front and back parts.
`default_nettype none
`include "polygon_area_convexity_bbox_core_defines.svh"

module pacb_job_q
	import pacb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_push,
	input  job_t q_in,
	output logic q_full,
	input  logic q_pop,
	output job_t q_head,
	output logic q_empty
);

	job_t                mem_q [JQ_DEPTH];
	logic [JQ_PTR_W-1:0] wr_ptr_q;
	logic [JQ_PTR_W-1:0] rd_ptr_q;
	logic [JQ_CNT_W-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	assign q_full  = (cnt_q == JQ_CNT_W'(JQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_push = q_push && !q_full;
	assign do_pop  = q_pop && !q_empty;
	assign q_head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_in;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`PACB_ASSERT_NEVER(a_jq_bound, cnt_q > JQ_CNT_W'(JQ_DEPTH), "job queue overfilled")
	`PACB_ASSERT_IMPLIES(a_jq_ptr_match, cnt_q == '0, rd_ptr_q == wr_ptr_q, "job queue pointers disagree when empty")

endmodule

`default_nettype wire

// ----- design/pacb_front.sv -----
// Front part: takes vertices, keeps the polygon window, box and count, builds jobs.
`default_nettype none

module pacb_front
	import pacb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  coord_t vertex_x,
	input  coord_t vertex_y,
	input  logic   final_vertex,
	input  logic   push,
	input  logic   q_full,
	output logic   job_push,
	output job_t   job
);

	coord_t first_x_q, first_y_q, second_x_q, second_y_q;
	coord_t older_x_q, older_y_q, recent_x_q, recent_y_q;
	box_t   box_q;
	count_t cnt_q;
	logic   ovf_q;

	logic   n_zero;
	logic   n_ge2;
	logic   below_max;
	box_t   box_d;
	count_t cnt_d;
	logic   ovf_d;

	assign job_push  = push && !q_full;
	assign n_zero    = (cnt_q == '0);
	assign n_ge2     = (cnt_q >= COUNT_W'(2));
	assign below_max = (cnt_q < COUNT_W'(MAX_VERTICES));
	assign cnt_d     = below_max ? cnt_q + 1'b1 : cnt_q;
	assign ovf_d     = ovf_q || !below_max;

	// running bounding box
	always_comb begin
		if (n_zero) begin
			box_d = '{min_x: vertex_x, min_y: vertex_y, max_x: vertex_x, max_y: vertex_y};
		end else begin
			box_d.min_x = (vertex_x < box_q.min_x) ? vertex_x : box_q.min_x;
			box_d.min_y = (vertex_y < box_q.min_y) ? vertex_y : box_q.min_y;
			box_d.max_x = (vertex_x > box_q.max_x) ? vertex_x : box_q.max_x;
			box_d.max_y = (vertex_y > box_q.max_y) ? vertex_y : box_q.max_y;
		end
	end

	// cross product operands for this vertex
	always_comb begin
		job = '0;
		if (!n_zero) begin
			job.area.ax = diff(recent_x_q, first_x_q);
			job.area.ay = diff(recent_y_q, first_y_q);
			job.area.bx = diff(vertex_x, first_x_q);
			job.area.by = diff(vertex_y, first_y_q);
		end
		// turn at the previous vertex
		job.turn_mid.ax = diff(recent_x_q, older_x_q);
		job.turn_mid.ay = diff(recent_y_q, older_y_q);
		job.turn_mid.bx = diff(vertex_x, older_x_q);
		job.turn_mid.by = diff(vertex_y, older_y_q);
		// wrap-around turns at the last and first vertices
		job.turn_last.ax  = diff(vertex_x, recent_x_q);
		job.turn_last.ay  = diff(vertex_y, recent_y_q);
		job.turn_last.bx  = diff(first_x_q, recent_x_q);
		job.turn_last.by  = diff(first_y_q, recent_y_q);
		job.turn_first.ax = diff(first_x_q, vertex_x);
		job.turn_first.ay = diff(first_y_q, vertex_y);
		job.turn_first.bx = diff(second_x_q, vertex_x);
		job.turn_first.by = diff(second_y_q, vertex_y);
		job.turn_mid_v = n_ge2;
		job.turn_end_v = n_ge2 && final_vertex;
		job.enough     = n_ge2;
		job.final_v    = final_vertex;
		job.box        = box_d;
		job.count      = cnt_d;
		job.ovf        = ovf_d;
	end

	// polygon window; cleared after the closing vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q  <= '0;
			first_y_q  <= '0;
			second_x_q <= '0;
			second_y_q <= '0;
			older_x_q  <= '0;
			older_y_q  <= '0;
			recent_x_q <= '0;
			recent_y_q <= '0;
			box_q      <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
		end else if (job_push) begin
			if (final_vertex) begin
				first_x_q  <= '0;
				first_y_q  <= '0;
				second_x_q <= '0;
				second_y_q <= '0;
				older_x_q  <= '0;
				older_y_q  <= '0;
				recent_x_q <= '0;
				recent_y_q <= '0;
				box_q      <= '0;
				cnt_q      <= '0;
				ovf_q      <= 1'b0;
			end else begin
				if (n_zero) begin
					first_x_q <= vertex_x;
					first_y_q <= vertex_y;
				end
				if (cnt_q == COUNT_W'(1)) begin
					second_x_q <= vertex_x;
					second_y_q <= vertex_y;
				end
				older_x_q  <= recent_x_q;
				older_y_q  <= recent_y_q;
				recent_x_q <= vertex_x;
				recent_y_q <= vertex_y;
				box_q      <= box_d;
				cnt_q      <= cnt_d;
				ovf_q      <= ovf_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/pacb_back.sv -----
// Back part: multiplies, accumulates area and turn extremes, forms and buffers results.
`default_nettype none
`include "polygon_area_convexity_bbox_core_defines.svh"

module pacb_back
	import pacb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [EPS_W-1:0] cfg_wr_data,
	input  job_t             jq_head,
	input  logic             jq_empty,
	output logic             jq_pop,
	output result_t          res,
	output logic             empty,
	input  logic             pop
);

	logic [EPS_W-1:0]    eps_q;
	logic                adv;
	logic                valid_s1;
	prods_t              prod_s1;
	logic                valid_s2;
	totals_t             tot_s2;
	area_t               area_acc_q;
	cross_t              tmin_acc_q;
	cross_t              tmax_acc_q;
	result_t             rb_mem_q [RB_DEPTH];
	logic [RB_PTR_W-1:0] rb_wr_q;
	logic [RB_PTR_W-1:0] rb_rd_q;
	logic [RB_CNT_W-1:0] rb_cnt_q;
	logic                rb_full;
	logic                rb_push;
	logic                rb_pop;

	prods_t              prod_d;
	cross_t              x_area, x_mid, x_last, x_first;
	area_t               area_d;
	cross_t              tmin_d, tmax_d;
	result_t             res_d;
	logic                cw;
	logic [CROSS_W:0]    neg_tmax;
	logic [CROSS_W:0]    eps_ext;

	// turn threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg_wr_en) begin
			eps_q <= cfg_wr_data;
		end
	end

	// the whole pipe moves unless a closing total waits on a full buffer
	assign rb_full = (rb_cnt_q == RB_CNT_W'(RB_DEPTH));
	assign adv     = !(valid_s2 && rb_full);
	assign jq_pop  = adv && !jq_empty;
	assign rb_push = valid_s2 && adv;
	assign rb_pop  = pop && !empty;

	// stage 1 products
	always_comb begin
		prod_d.area.ab       = mul(jq_head.area.ax, jq_head.area.by);
		prod_d.area.ba       = mul(jq_head.area.ay, jq_head.area.bx);
		prod_d.turn_mid.ab   = mul(jq_head.turn_mid.ax, jq_head.turn_mid.by);
		prod_d.turn_mid.ba   = mul(jq_head.turn_mid.ay, jq_head.turn_mid.bx);
		prod_d.turn_last.ab  = mul(jq_head.turn_last.ax, jq_head.turn_last.by);
		prod_d.turn_last.ba  = mul(jq_head.turn_last.ay, jq_head.turn_last.bx);
		prod_d.turn_first.ab = mul(jq_head.turn_first.ax, jq_head.turn_first.by);
		prod_d.turn_first.ba = mul(jq_head.turn_first.ay, jq_head.turn_first.bx);
		prod_d.turn_mid_v    = jq_head.turn_mid_v;
		prod_d.turn_end_v    = jq_head.turn_end_v;
		prod_d.enough        = jq_head.enough;
		prod_d.final_v       = jq_head.final_v;
		prod_d.box           = jq_head.box;
		prod_d.count         = jq_head.count;
		prod_d.ovf           = jq_head.ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= jq_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (jq_pop) begin
			prod_s1 <= prod_d;
		end
	end

	// crosses, area sum and turn extremes
	assign x_area  = cross_of(prod_s1.area);
	assign x_mid   = cross_of(prod_s1.turn_mid);
	assign x_last  = cross_of(prod_s1.turn_last);
	assign x_first = cross_of(prod_s1.turn_first);
	assign area_d  = area_acc_q + AREA_W'(x_area);

	always_comb begin
		tmin_d = tmin_acc_q;
		tmax_d = tmax_acc_q;
		if (prod_s1.turn_mid_v) begin
			if (x_mid < tmin_d) tmin_d = x_mid;
			if (x_mid > tmax_d) tmax_d = x_mid;
		end
		if (prod_s1.turn_end_v) begin
			if (x_last < tmin_d) tmin_d = x_last;
			if (x_last > tmax_d) tmax_d = x_last;
			if (x_first < tmin_d) tmin_d = x_first;
			if (x_first > tmax_d) tmax_d = x_first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_acc_q <= '0;
			tmin_acc_q <= TURN_HI;
			tmax_acc_q <= TURN_LO;
			valid_s2   <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && prod_s1.final_v;
			if (valid_s1) begin
				if (prod_s1.final_v) begin
					area_acc_q <= '0;
					tmin_acc_q <= TURN_HI;
					tmax_acc_q <= TURN_LO;
				end else begin
					area_acc_q <= area_d;
					tmin_acc_q <= tmin_d;
					tmax_acc_q <= tmax_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && prod_s1.final_v) begin
			tot_s2.area   <= area_d;
			tot_s2.tmin   <= tmin_d;
			tot_s2.tmax   <= tmax_d;
			tot_s2.enough <= prod_s1.enough;
			tot_s2.box    <= prod_s1.box;
			tot_s2.count  <= prod_s1.count;
			tot_s2.ovf    <= prod_s1.ovf;
		end
	end

	// winding, magnitude and convexity of the closed polygon
	assign cw       = tot_s2.area[AREA_W-1];
	assign neg_tmax = -{tot_s2.tmax[CROSS_W-1], tot_s2.tmax};
	assign eps_ext  = {{(CROSS_W+1-EPS_W){1'b0}}, eps_q};

	always_comb begin
		res_d.twice_area    = cw ? -tot_s2.area : tot_s2.area;
		res_d.was_clockwise = cw;
		if (!tot_s2.enough) begin
			res_d.convex = 1'b0;
		end else if (cw) begin
			res_d.convex = $signed(neg_tmax) > $signed(eps_ext);
		end else begin
			res_d.convex = $signed({tot_s2.tmin[CROSS_W-1], tot_s2.tmin}) > $signed(eps_ext);
		end
		res_d.box   = tot_s2.box;
		res_d.count = tot_s2.count;
		res_d.ovf   = tot_s2.ovf;
	end

	// result buffer
	always_ff @(posedge clk) begin
		if (rb_push) begin
			rb_mem_q[rb_wr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_wr_q  <= '0;
			rb_rd_q  <= '0;
			rb_cnt_q <= '0;
		end else begin
			if (rb_push) begin
				rb_wr_q <= rb_wr_q + 1'b1;
			end
			if (rb_pop) begin
				rb_rd_q <= rb_rd_q + 1'b1;
			end
			if (rb_push && !rb_pop) begin
				rb_cnt_q <= rb_cnt_q + 1'b1;
			end else if (rb_pop && !rb_push) begin
				rb_cnt_q <= rb_cnt_q - 1'b1;
			end
		end
	end

	assign empty = (rb_cnt_q == '0);
	assign res   = rb_mem_q[rb_rd_q];

	`PACB_ASSERT_NEVER(a_rb_bound, rb_cnt_q > RB_CNT_W'(RB_DEPTH), "result buffer overfilled")
	`PACB_ASSERT_NEXT(a_acc_clear, adv && valid_s1 && prod_s1.final_v, area_acc_q == '0 && tmin_acc_q == TURN_HI && tmax_acc_q == TURN_LO, "accumulators not cleared after closing vertex")
	`PACB_ASSERT_NEXT(a_s2_hold, valid_s2 && !adv, valid_s2 && $stable(tot_s2), "stalled closing total lost or changed")

endmodule

`default_nettype wire

// ----- design/polygon_area_convexity_bbox_core.sv -----
// Top level of the polygon area, winding, convexity and bounding box core.
//
// Usage:
//   Vertices go in through a queue-style port: an item is taken at a rising
//   edge with push high and full low. final_vertex marks the last vertex of
//   a polygon; only that vertex yields a result item. Results come out of a
//   queue-style port: while empty is low the oldest result is on the ports,
//   and it is taken at an edge with pop high.
//   turn_epsilon is written through cfg_wr_en / cfg_wr_data while idle; the
//   user must keep to this, as the block itself does not enforce it.
// Path: job queue, product stage, totals stage, then the result buffer.
// Throughput: one vertex per cycle unless the back part holds, set by the
//   single product stage and the area and turn accumulate in the back part.
// Stalls: when the receiver does not pop, the two-entry result buffer fills,
//   then the back part holds and the four-entry job queue fills before full
//   rises. Vertices that close no polygon still pass until a total waits.
// Reset: arst_n clears the polygon state, queues and turn_epsilon at once;
//   the block takes items in the first cycle after release.
`default_nettype none

module polygon_area_convexity_bbox_core
	import pacb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [EPS_W-1:0]     cfg_wr_data,
	input  logic signed [COORD_W-1:0] vertex_x,
	input  logic signed [COORD_W-1:0] vertex_y,
	input  logic                 final_vertex,
	input  logic                 push,
	output logic                 full,
	output logic [AREA_W-1:0]    twice_area,
	output logic                 was_clockwise,
	output logic                 convex,
	output logic signed [COORD_W-1:0] box_min_x,
	output logic signed [COORD_W-1:0] box_min_y,
	output logic signed [COORD_W-1:0] box_max_x,
	output logic signed [COORD_W-1:0] box_max_y,
	output logic [COUNT_W-1:0]   vertex_count,
	output logic                 count_overflow,
	output logic                 empty,
	input  logic                 pop
);

	logic    job_push;
	job_t    job;
	logic    jq_full;
	logic    jq_pop;
	job_t    jq_head;
	logic    jq_empty;
	result_t res;

	assign full = jq_full;

	pacb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.final_vertex (final_vertex),
		.push         (push),
		.q_full       (jq_full),
		.job_push     (job_push),
		.job          (job)
	);

	pacb_job_q u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (job_push),
		.q_in    (job),
		.q_full  (jq_full),
		.q_pop   (jq_pop),
		.q_head  (jq_head),
		.q_empty (jq_empty)
	);

	pacb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.jq_head     (jq_head),
		.jq_empty    (jq_empty),
		.jq_pop      (jq_pop),
		.res         (res),
		.empty       (empty),
		.pop         (pop)
	);

	// result fields onto their ports
	assign twice_area     = res.twice_area;
	assign was_clockwise  = res.was_clockwise;
	assign convex         = res.convex;
	assign box_min_x      = res.box.min_x;
	assign box_min_y      = res.box.min_y;
	assign box_max_x      = res.box.max_x;
	assign box_max_y      = res.box.max_y;
	assign vertex_count   = res.count;
	assign count_overflow = res.ovf;

endmodule

`default_nettype wire
